/* rtl/mpc_pkg.sv */
// mpc_pkg: widths, codes, entry and port-group types, max-plus arithmetic
// shared by every file of the longest-path closure engine but mpc_dist_ram
// depends on nothing
package mpc_pkg;

    localparam int MAX_NODES  = 16;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int DEPTH   = MAX_NODES * MAX_NODES;
    localparam int ADDR_W  = $clog2(DEPTH);

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int ROW_W     = 4;
    localparam int WEIGHT_W  = 32;
    localparam int NCOUNT_W  = 5;
    localparam int THRESH_W  = 32;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_ZERO_SELF  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 5'd16;

    localparam logic signed [VALUE_BITS-1:0] VAL_MAX_V = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN_V = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam longint VAL_MAX_L = longint'(VAL_MAX_V);
    localparam longint VAL_MIN_L = longint'(VAL_MIN_V);
    localparam longint OUT_MAX_L = 64'sd2147483647;
    localparam longint OUT_MIN_L = -64'sd2147483648;

    typedef struct packed {
        logic                          ninf;
        logic signed [VALUE_BITS-1:0]  val;
    } entry_t;

    typedef struct packed {
        logic [NCOUNT_W-1:0]        node_count;
        logic                       zero_self_edges;
        logic signed [THRESH_W-1:0] cycle_threshold;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } ram_req_t;

    function automatic logic [ADDR_W-1:0] mk_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_NODES + int'(c));
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] sat_in(logic signed [WEIGHT_W-1:0] w);
        longint x;
        x = longint'(w);
        if (x > VAL_MAX_L)
            return VAL_MAX_V;
        else if (x < VAL_MIN_L)
            return VAL_MIN_V;
        return VALUE_BITS'(x);
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] sat_out(logic signed [VALUE_BITS-1:0] v);
        longint x;
        x = longint'(v);
        if (x > OUT_MAX_L)
            x = OUT_MAX_L;
        else if (x < OUT_MIN_L)
            x = OUT_MIN_L;
        return WEIGHT_W'(x);
    endfunction

    // max of current entry, optional zero self edge and path through k
    function automatic entry_t mp_relax(entry_t cur, entry_t uk, entry_t kv, logic self_zero);
        entry_t                     best;
        entry_t                     cand;
        logic signed [VALUE_BITS:0] sum;
        best = cur;
        if (self_zero && (cur.ninf || $signed(cur.val) < 0))
        begin
            best.ninf = 1'b0;
            best.val  = '0;
        end
        sum = {uk.val[VALUE_BITS-1], uk.val} + {kv.val[VALUE_BITS-1], kv.val};
        cand.ninf = uk.ninf | kv.ninf;
        if (sum[VALUE_BITS] != sum[VALUE_BITS-1])
            cand.val = sum[VALUE_BITS] ? VAL_MIN_V : VAL_MAX_V;
        else
            cand.val = sum[VALUE_BITS-1:0];
        if (!cand.ninf && (best.ninf || $signed(cand.val) > $signed(best.val)))
            best = cand;
        return best;
    endfunction

endpackage

/* rtl/mpc_dist_ram.sv */
// mpc_dist_ram: generic synchronous ram, one write port, two registered read ports
// depends on nothing
module mpc_dist_ram #(
    parameter int DATA_W = 33,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [DATA_W-1:0] rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/mpc_seq.sv */
// mpc_seq: op decode, k/u/v closure sequencer with read-modify-write pipeline,
// diagonal scan and result register; depends on mpc_pkg
module mpc_seq (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mpc_pkg::cfg_t                          cfg,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  logic [mpc_pkg::OP_W-1:0]               operation,
    input  logic [mpc_pkg::ROW_W-1:0]              row_index,
    input  logic [mpc_pkg::ROW_W-1:0]              col_index,
    input  logic signed [mpc_pkg::WEIGHT_W-1:0]    weight,
    input  logic                                   weight_is_neg_inf,
    output mpc_pkg::ram_req_t                      ram_req,
    input  mpc_pkg::entry_t                        rd_a,
    input  mpc_pkg::entry_t                        rd_b,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [mpc_pkg::WEIGHT_W-1:0]    entry_value,
    output logic                                   entry_is_neg_inf,
    output logic                                   positive_cycle
);

    import mpc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD_WAIT, S_UK_RD, S_STREAM, S_DRAIN, S_DIAG, S_DIAG_END, S_RESULT
    } state_t;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            k_reg, k_next, u_reg, u_next, v_reg, v_next;
    entry_t                      uk_reg, uk_next;
    logic                        p_upd_reg, p_upd_next;
    logic                        p_diag_reg, p_diag_next;
    logic                        p_uk_reg, p_uk_next;
    logic                        p_fwd_reg, p_fwd_next;
    logic                        p_self_reg, p_self_next;
    logic [ADDR_W-1:0]           p_addr_reg, p_addr_next;
    logic                        found_reg, found_next;
    logic signed [WEIGHT_W-1:0]  res_val_reg, res_val_next;
    logic                        res_ninf_reg, res_ninf_next;
    logic                        res_cyc_reg, res_cyc_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [WEIGHT_W-1:0]  out_val_reg, out_val_next;
    logic                        out_ninf_reg, out_ninf_next;
    logic                        out_cyc_reg, out_cyc_next;

    logic [CNT_W-1:0]            n_use;
    logic                        k_last, u_last, v_last;
    logic                        in_range;
    logic [IDX_W-1:0]            row_idx, col_idx;
    entry_t                      relaxed;
    entry_t                      wr_entry;
    logic                        diag_hit;

    always_comb
    begin
        if (cfg.node_count == '0)
            n_use = CNT_W'(1);
        else if (int'(cfg.node_count) > MAX_NODES)
            n_use = CNT_W'(MAX_NODES);
        else
            n_use = CNT_W'(cfg.node_count);
    end

    assign k_last   = (CNT_W'(k_reg) == n_use - CNT_W'(1));
    assign u_last   = (CNT_W'(u_reg) == n_use - CNT_W'(1));
    assign v_last   = (CNT_W'(v_reg) == n_use - CNT_W'(1));
    assign in_range = (int'(row_index) < int'(n_use)) && (int'(col_index) < int'(n_use));
    assign row_idx  = IDX_W'(row_index);
    assign col_idx  = IDX_W'(col_index);

    assign relaxed  = mp_relax(rd_a, uk_reg, rd_b, p_self_reg & cfg.zero_self_edges);
    assign diag_hit = p_diag_reg && !rd_a.ninf &&
                      (longint'(rd_a.val) > longint'(cfg.cycle_threshold));

    always_comb
    begin
        wr_entry.ninf = weight_is_neg_inf;
        wr_entry.val  = weight_is_neg_inf ? '0 : sat_in(weight);
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        p_upd_next    = 1'b0;
        p_diag_next   = 1'b0;
        p_uk_next     = 1'b0;
        p_fwd_next    = 1'b0;
        p_self_next   = 1'b0;
        p_addr_next   = p_addr_reg;
        found_next    = found_reg | diag_hit;
        res_val_next  = res_val_reg;
        res_ninf_next = res_ninf_reg;
        res_cyc_next  = res_cyc_reg;
        out_valid_next = out_valid_reg & ~result_ready;
        out_val_next  = out_val_reg;
        out_ninf_next = out_ninf_reg;
        out_cyc_next  = out_cyc_reg;

        ram_req.we      = p_upd_reg;
        ram_req.waddr   = p_addr_reg;
        ram_req.wdata   = relaxed;
        ram_req.raddr_a = '0;
        ram_req.raddr_b = '0;

        // path through k updates row k: keep the held column entry current
        if (p_uk_reg)
            uk_next = rd_b;
        else if (p_upd_reg && p_fwd_reg)
            uk_next = relaxed;
        else
            uk_next = uk_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (operation)
                        OP_WRITE:
                        begin
                            if (in_range)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = mk_addr(row_idx, col_idx);
                                ram_req.wdata = wr_entry;
                            end
                        end
                        OP_CLOSE:
                        begin
                            k_next     = '0;
                            u_next     = '0;
                            v_next     = '0;
                            found_next = 1'b0;
                            state_next = S_UK_RD;
                        end
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                ram_req.raddr_a = mk_addr(row_idx, col_idx);
                                state_next      = S_RD_WAIT;
                            end
                            else
                            begin
                                res_val_next  = '0;
                                res_ninf_next = 1'b1;
                                res_cyc_next  = 1'b0;
                                state_next    = S_RESULT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                res_val_next  = rd_a.ninf ? '0 : sat_out(rd_a.val);
                res_ninf_next = rd_a.ninf;
                res_cyc_next  = 1'b0;
                state_next    = S_RESULT;
            end
            S_UK_RD:
            begin
                ram_req.raddr_b = mk_addr(k_reg, u_reg);
                p_uk_next       = 1'b1;
                state_next      = S_STREAM;
            end
            S_STREAM:
            begin
                ram_req.raddr_a = mk_addr(v_reg, u_reg);
                ram_req.raddr_b = mk_addr(v_reg, k_reg);
                p_upd_next      = 1'b1;
                p_addr_next     = mk_addr(v_reg, u_reg);
                p_fwd_next      = (v_reg == k_reg);
                p_self_next     = (v_reg == u_reg);
                if (v_last)
                begin
                    v_next = '0;
                    if (u_last)
                    begin
                        u_next = '0;
                        if (k_last)
                            state_next = S_DRAIN;
                        else
                        begin
                            k_next     = k_reg + IDX_W'(1);
                            state_next = S_UK_RD;
                        end
                    end
                    else
                    begin
                        u_next     = u_reg + IDX_W'(1);
                        state_next = S_UK_RD;
                    end
                end
                else
                    v_next = v_reg + IDX_W'(1);
            end
            S_DRAIN:
            begin
                v_next     = '0;
                state_next = S_DIAG;
            end
            S_DIAG:
            begin
                ram_req.raddr_a = mk_addr(v_reg, v_reg);
                p_diag_next     = 1'b1;
                if (v_last)
                    state_next = S_DIAG_END;
                else
                    v_next = v_reg + IDX_W'(1);
            end
            S_DIAG_END:
            begin
                res_val_next  = '0;
                res_ninf_next = 1'b0;
                res_cyc_next  = found_next;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_ninf_next  = res_ninf_reg;
                    out_cyc_next   = res_cyc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            uk_reg        <= '0;
            p_upd_reg     <= 1'b0;
            p_diag_reg    <= 1'b0;
            p_uk_reg      <= 1'b0;
            p_fwd_reg     <= 1'b0;
            p_self_reg    <= 1'b0;
            p_addr_reg    <= '0;
            found_reg     <= 1'b0;
            res_val_reg   <= '0;
            res_ninf_reg  <= 1'b0;
            res_cyc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_val_reg   <= '0;
            out_ninf_reg  <= 1'b0;
            out_cyc_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            uk_reg        <= uk_next;
            p_upd_reg     <= p_upd_next;
            p_diag_reg    <= p_diag_next;
            p_uk_reg      <= p_uk_next;
            p_fwd_reg     <= p_fwd_next;
            p_self_reg    <= p_self_next;
            p_addr_reg    <= p_addr_next;
            found_reg     <= found_next;
            res_val_reg   <= res_val_next;
            res_ninf_reg  <= res_ninf_next;
            res_cyc_reg   <= res_cyc_next;
            out_valid_reg <= out_valid_next;
            out_val_reg   <= out_val_next;
            out_ninf_reg  <= out_ninf_next;
            out_cyc_reg   <= out_cyc_next;
        end
    end

    assign item_ready       = (state_reg == S_IDLE);
    assign result_valid     = out_valid_reg;
    assign entry_value      = out_val_reg;
    assign entry_is_neg_inf = out_ninf_reg;
    assign positive_cycle   = out_cyc_reg;

endmodule

/* rtl/max_plus_longest_path_closure.sv */
// max_plus_longest_path_closure: top level, apb register file, distance ram, sequencer
// depends on mpc_pkg, mpc_dist_ram, mpc_seq
//
//   channel   signals                                               beat taken when
//   item      item_valid/item_ready, operation..weight_is_neg_inf   item_valid & item_ready
//   result    result_valid/result_ready, entry_value..positive_cycle result_valid & result_ready
//   apb       psel/penable/pwrite/paddr/pwdata/prdata/pready        psel & penable (& pwrite to write)
//
// write: ram written as the beat is taken; read: S_RD_WAIT loads the res registers, S_RESULT
// the result register once free; closure: per k and u, S_UK_RD reads entry (k,u), then S_STREAM
// does one entry update per cycle over v through the single write port of the distance ram
// reset clears control and registers only; matrix contents are undefined until written
// a waiting result does not block the next beat; a later read or closure waits in S_RESULT
module max_plus_longest_path_closure (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mpc_pkg::PADDR_W-1:0]         paddr,
    input  logic [mpc_pkg::PDATA_W-1:0]         pwdata,
    output logic [mpc_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [mpc_pkg::OP_W-1:0]            operation,
    input  logic [mpc_pkg::ROW_W-1:0]           row_index,
    input  logic [mpc_pkg::ROW_W-1:0]           col_index,
    input  logic signed [mpc_pkg::WEIGHT_W-1:0] weight,
    input  logic                                weight_is_neg_inf,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [mpc_pkg::WEIGHT_W-1:0] entry_value,
    output logic                                entry_is_neg_inf,
    output logic                                positive_cycle
);

    import mpc_pkg::*;

    cfg_t              cfg_reg;
    ram_req_t          ram_req;
    logic [$bits(entry_t)-1:0] rdata_a, rdata_b;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count      <= NODE_COUNT_RST;
            cfg_reg.zero_self_edges <= 1'b0;
            cfg_reg.cycle_threshold <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_NODE_COUNT: cfg_reg.node_count      <= pwdata[NCOUNT_W-1:0];
                REG_ZERO_SELF:  cfg_reg.zero_self_edges <= pwdata[0];
                REG_THRESHOLD:  cfg_reg.cycle_threshold <= $signed(pwdata[THRESH_W-1:0]);
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NODE_COUNT: prdata = PDATA_W'(cfg_reg.node_count);
            REG_ZERO_SELF:  prdata = PDATA_W'(cfg_reg.zero_self_edges);
            REG_THRESHOLD:  prdata = PDATA_W'(cfg_reg.cycle_threshold);
            default:        prdata = '0;
        endcase
    end

    mpc_dist_ram #(
        .DATA_W ($bits(entry_t)),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .raddr_a (ram_req.raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (ram_req.raddr_b),
        .rdata_b (rdata_b)
    );

    mpc_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .operation         (operation),
        .row_index         (row_index),
        .col_index         (col_index),
        .weight            (weight),
        .weight_is_neg_inf (weight_is_neg_inf),
        .ram_req           (ram_req),
        .rd_a              (entry_t'(rdata_a)),
        .rd_b              (entry_t'(rdata_b)),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .entry_value       (entry_value),
        .entry_is_neg_inf  (entry_is_neg_inf),
        .positive_cycle    (positive_cycle)
    );

endmodule

/* rtl/mpc_checker.sv */
// mpc_checker: port-level assertions for the closure engine, bound to the top level
// depends on mpc_pkg and max_plus_longest_path_closure
module mpc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_valid,
    input logic                                item_ready,
    input logic [mpc_pkg::OP_W-1:0]            operation,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic signed [mpc_pkg::WEIGHT_W-1:0] entry_value,
    input logic                                entry_is_neg_inf,
    input logic                                positive_cycle
);

    import mpc_pkg::*;

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
        result_valid && $stable(entry_value) && $stable(entry_is_neg_inf)
        && $stable(positive_cycle))
        else $error("stalled result beat changed");

    // minus infinity reads carry a zero value
    a_ninf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && entry_is_neg_inf |-> entry_value == '0 && !positive_cycle)
        else $error("minus infinity result with nonzero fields");

    // cycle flag only on closure results, which carry no entry
    a_cycle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && positive_cycle |-> entry_value == '0 && !entry_is_neg_inf)
        else $error("positive cycle flag on an entry result");

    // a read or closure beat busies the block for the next cycle
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (operation == OP_READ || operation == OP_CLOSE)
        |=> !item_ready)
        else $error("item taken while read or closure in flight");

endmodule

bind max_plus_longest_path_closure mpc_checker u_chk (.*);
